### rtl/core/xypd_pkg.sv
// ----------------------------------------------------------------------------
// xypd_pkg
// Shared constants, register indexes and config type of the point decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package xypd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int LIMIT_W         = 32;
  localparam int SKIP_W          = 16;
  localparam int MODE_W          = 2;
  localparam int FRAC_W          = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int OUTQ_DEPTH      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOG    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOG    = 3'd5;

  // reduction modes
  localparam logic [MODE_W-1:0] MODE_SKIP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SKIP_W-1:0]  interval;
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
    logic               x_log;
    logic               y_log;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/core/xypd_in_if.sv
// ----------------------------------------------------------------------------
// xypd_in_if
// Input point channel: valid/ready with one (x,y) point word.
// ----------------------------------------------------------------------------
`default_nettype none

interface xypd_in_if #(
  parameter int COORD_WIDTH = xypd_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_value;
  logic signed [COORD_WIDTH-1:0] y_value;
  logic                          first_point;
  logic                          final_point;

  modport source (output valid, x_value, y_value, first_point, final_point,
                  input ready);
  modport sink   (input valid, x_value, y_value, first_point, final_point,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/xypd_out_if.sv
// ----------------------------------------------------------------------------
// xypd_out_if
// Result channel: valid/ready with one kept point word.
// ----------------------------------------------------------------------------
`default_nettype none

interface xypd_out_if #(
  parameter int COORD_WIDTH = xypd_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] kept_x;
  logic signed [COORD_WIDTH-1:0] kept_y;
  logic                          run_end;

  modport source (output valid, kept_x, kept_y, run_end, input ready);
  modport sink   (input valid, kept_x, kept_y, run_end, output ready);
endinterface

`default_nettype wire

### rtl/core/xypd_change.sv
// ----------------------------------------------------------------------------
// xypd_change
// Change test between two signed coordinates: absolute difference against a
// limit, or in log mode hi*2^16 >= limit*lo for two positive values.
// ----------------------------------------------------------------------------
`default_nettype none

module xypd_change #(
  parameter int COORD_WIDTH = xypd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic signed [COORD_WIDTH-1:0]      a,
  input  wire logic signed [COORD_WIDTH-1:0]      b,
  input  wire logic [xypd_pkg::LIMIT_W-1:0]       limit,
  input  wire logic                               log_mode,
  output logic                                    hit
);

  localparam int W  = COORD_WIDTH;
  localparam int LW = xypd_pkg::LIMIT_W;
  localparam int DW = (W > LW) ? W : LW;
  localparam int PW = W + LW;

  logic signed [W:0] diff;
  logic [W:0]        mag;
  logic              a_ge_b;
  logic [W-1:0]      hi;
  logic [W-1:0]      lo;
  logic [PW-1:0]     lhs;
  logic [PW-1:0]     rhs;
  logic              a_pos;
  logic              b_pos;
  logic              lin_hit;
  logic              log_hit;

  always_comb begin
    diff    = {a[W-1], a} - {b[W-1], b};
    a_ge_b  = !diff[W];
    mag     = a_ge_b ? diff : -diff;
    lin_hit = DW'(mag[W-1:0]) >= DW'(limit);

    hi      = a_ge_b ? a : b;
    lo      = a_ge_b ? b : a;
    lhs     = PW'(hi) << xypd_pkg::FRAC_W;
    rhs     = PW'(limit) * PW'(lo);
    a_pos   = !a[W-1] && (a != '0);
    b_pos   = !b[W-1] && (b != '0);
    log_hit = a_pos && b_pos && (lhs >= rhs);

    hit     = log_mode ? log_hit : lin_hit;
  end

endmodule

`default_nettype wire

### rtl/core/xypd_keep.sv
// ----------------------------------------------------------------------------
// xypd_keep
// Keep decision and decimator state: skip counter, previous point, last kept
// point. Gives zero, one or two result words per processed point.
// ----------------------------------------------------------------------------
`default_nettype none

module xypd_keep #(
  parameter int COORD_WIDTH = xypd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire xypd_pkg::cfg_t                cfg,
  input  wire logic                          fire,
  input  wire logic signed [COORD_WIDTH-1:0] x,
  input  wire logic signed [COORD_WIDTH-1:0] y,
  input  wire logic                          first,
  input  wire logic                          final_pt,
  output logic [1:0]                         res_cnt,
  output logic [2*COORD_WIDTH:0]             res0,
  output logic [2*COORD_WIDTH:0]             res1
);

  localparam int W  = COORD_WIDTH;
  localparam int SW = xypd_pkg::SKIP_W;

  logic [SW-1:0]       skip_count_r, skip_count_nxt;
  logic signed [W-1:0] prev_x_r, prev_x_nxt;
  logic signed [W-1:0] prev_y_r, prev_y_nxt;
  logic                prev_kept_r, prev_kept_nxt;
  logic signed [W-1:0] lk_x_r, lk_x_nxt;
  logic signed [W-1:0] lk_y_r, lk_y_nxt;

  logic          use_skip;
  logic          use_change;
  logic [SW-1:0] cnt0;
  logic [SW:0]   cnt_inc;
  logic [SW-1:0] cnt_after;
  logic          keep0;
  logic          keep1;
  logic          keep;
  logic          emit_prev;
  logic          ych_prev;
  logic          ych_lk;
  logic          xch_lk;

  xypd_change #(.COORD_WIDTH(W)) u_ych_prev (
    .a(y), .b(prev_y_r), .limit(cfg.y_limit), .log_mode(cfg.y_log), .hit(ych_prev)
  );

  xypd_change #(.COORD_WIDTH(W)) u_ych_lk (
    .a(y), .b(lk_y_r), .limit(cfg.y_limit), .log_mode(cfg.y_log), .hit(ych_lk)
  );

  xypd_change #(.COORD_WIDTH(W)) u_xch_lk (
    .a(x), .b(lk_x_r), .limit(cfg.x_limit), .log_mode(cfg.x_log), .hit(xch_lk)
  );

  always_comb begin
    use_skip   = cfg.mode != xypd_pkg::MODE_CHANGE;
    use_change = cfg.mode != xypd_pkg::MODE_SKIP;

    cnt0    = first ? cfg.interval : skip_count_r;
    cnt_inc = (SW+1)'(cnt0) + 1'b1;
    if (use_skip) begin
      cnt_after = cnt_inc[SW] ? '1 : cnt_inc[SW-1:0];
      keep0     = cnt_inc > (SW+1)'(cfg.interval);
    end else begin
      cnt_after = cnt0;
      keep0     = first || final_pt;
    end

    emit_prev = !keep0 && use_change && ych_prev && !prev_kept_r;
    keep1     = keep0 || (use_change && ych_prev);
    keep      = keep1 || (use_change && (ych_lk || xch_lk));

    res_cnt = 2'(emit_prev) + 2'(keep);
    res1    = {x, y, 1'b1};
    res0    = emit_prev ? {prev_x_r, prev_y_r, 1'b0} : res1;

    skip_count_nxt = skip_count_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    prev_kept_nxt  = prev_kept_r;
    lk_x_nxt       = lk_x_r;
    lk_y_nxt       = lk_y_r;
    if (fire) begin
      prev_x_nxt    = x;
      prev_y_nxt    = y;
      prev_kept_nxt = keep;
      if (keep) begin
        lk_x_nxt       = x;
        lk_y_nxt       = y;
        skip_count_nxt = '0;
      end else begin
        skip_count_nxt = cnt_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_kept_r  <= 1'b0;
      lk_x_r       <= '0;
      lk_y_r       <= '0;
    end else begin
      skip_count_r <= skip_count_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      prev_kept_r  <= prev_kept_nxt;
      lk_x_r       <= lk_x_nxt;
      lk_y_r       <= lk_y_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/xypd_outq.sv
// ----------------------------------------------------------------------------
// xypd_outq
// Small result queue: up to two words pushed per cycle, one popped.
// ----------------------------------------------------------------------------
`default_nettype none

module xypd_outq #(
  parameter int DATA_W = 2 * xypd_pkg::COORD_WIDTH_DEF + 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push_cnt,
  input  wire logic [DATA_W-1:0] push0,
  input  wire logic [DATA_W-1:0] push1,
  output logic                   room,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int DEPTH = xypd_pkg::OUTQ_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              pop;
  logic [AW-1:0]     wptr_p1;

  always_comb begin
    pop       = pop_valid && pop_ready;
    wptr_p1   = wptr_r + 1'b1;
    wptr_nxt  = wptr_r + AW'(push_cnt);
    rptr_nxt  = rptr_r + AW'(pop);
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
    room      = count_r <= CW'(DEPTH - 2);
    pop_valid = count_r != '0;
    pop_data  = mem[rptr_r];
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/xy_point_decimator_core.sv
// ----------------------------------------------------------------------------
// xy_point_decimator_core
// Thins a stream of signed Q16.16 (x,y) points by skip count and change tests.
// ----------------------------------------------------------------------------
// A point word is taken into an input register, decided combinationally and
// its results (none, one or two words) go into a four-word output queue.
// Points are accepted every cycle while each gives at most one result and the
// result port is not stalled. Two results (a dropped previous point re-emitted,
// then the point) grow the queue, as the result port moves one word per cycle;
// points wait while it lacks room for two. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata and must only change while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module xy_point_decimator_core #(
  parameter int COORD_WIDTH = xypd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  xypd_in_if.sink                                  in_port,
  xypd_out_if.source                               out_port,
  input  wire logic                                cfg_we,
  input  wire logic [xypd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [xypd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 1;

  xypd_pkg::cfg_t cfg_r, cfg_nxt;

  logic                hold_v_r, hold_v_nxt;
  logic signed [W-1:0] x_r;
  logic signed [W-1:0] y_r;
  logic                first_r;
  logic                final_r;
  logic                in_acc;
  logic                fire;
  logic                room;
  logic [1:0]          res_cnt;
  logic [DW-1:0]       res0;
  logic [DW-1:0]       res1;
  logic [DW-1:0]       q_data;

  // config
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        xypd_pkg::REG_MODE:     cfg_nxt.mode     = cfg_wdata[xypd_pkg::MODE_W-1:0];
        xypd_pkg::REG_INTERVAL: cfg_nxt.interval = cfg_wdata[xypd_pkg::SKIP_W-1:0];
        xypd_pkg::REG_X_LIMIT:  cfg_nxt.x_limit  = cfg_wdata[xypd_pkg::LIMIT_W-1:0];
        xypd_pkg::REG_Y_LIMIT:  cfg_nxt.y_limit  = cfg_wdata[xypd_pkg::LIMIT_W-1:0];
        xypd_pkg::REG_X_LOG:    cfg_nxt.x_log    = cfg_wdata[0];
        xypd_pkg::REG_Y_LOG:    cfg_nxt.y_log    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= xypd_pkg::MODE_SKIP;
      cfg_r.interval <= '0;
      cfg_r.x_limit  <= xypd_pkg::LIMIT_RESET;
      cfg_r.y_limit  <= xypd_pkg::LIMIT_RESET;
      cfg_r.x_log    <= 1'b0;
      cfg_r.y_log    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register
  always_comb begin
    fire          = hold_v_r && room;
    in_port.ready = !hold_v_r || fire;
    in_acc        = in_port.valid && in_port.ready;
    hold_v_nxt    = in_acc ? 1'b1 : (fire ? 1'b0 : hold_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r     <= in_port.x_value;
      y_r     <= in_port.y_value;
      first_r <= in_port.first_point;
      final_r <= in_port.final_point;
    end
  end

  xypd_keep #(.COORD_WIDTH(W)) u_keep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fire     (fire),
    .x        (x_r),
    .y        (y_r),
    .first    (first_r),
    .final_pt (final_r),
    .res_cnt  (res_cnt),
    .res0     (res0),
    .res1     (res1)
  );

  xypd_outq #(.DATA_W(DW)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (fire ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .pop_valid (out_port.valid),
    .pop_ready (out_port.ready),
    .pop_data  (q_data)
  );

  assign out_port.kept_x  = q_data[DW-1:W+1];
  assign out_port.kept_y  = q_data[W:1];
  assign out_port.run_end = q_data[0];

endmodule

`default_nettype wire
